// ----- rtl/rtsf_pkg.sv -----
package rtsf_pkg;

  localparam int NUM_COLS  = 8;
  localparam int NUM_ATOMS = 4;
  localparam int COL_W     = 32;
  localparam int FLD_W     = 3;
  localparam int TAG_W     = 4;
  localparam int HASH_W    = 64;
  localparam int IDX_W     = 3;

  localparam logic [HASH_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;

  typedef enum logic [1:0] {
    MODE_ONE    = 2'd0,
    MODE_BOTH   = 2'd1,
    MODE_EITHER = 2'd2,
    MODE_CNF    = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_HASH_SEED   = 3'd0,
    REG_EXPR_MODE   = 3'd1,
    REG_ATOM_FIELDS = 3'd2,
    REG_ATOM_VALUE0 = 3'd3,
    REG_ATOM_VALUE1 = 3'd4,
    REG_ATOM_VALUE2 = 3'd5,
    REG_ATOM_VALUE3 = 3'd6
  } cfg_reg_t;

  localparam logic [NUM_ATOMS*FLD_W-1:0] ATOM_FIELDS_RST = 12'd1672;

  // settled configuration plus the keys derived from it
  typedef struct packed {
    mode_t                                expr_mode;
    logic [NUM_ATOMS*FLD_W-1:0]           atom_fields;
    logic [NUM_ATOMS-1:0][COL_W-1:0]      atom_value;
    logic [HASH_W-1:0]                    seed_mix;
    logic [NUM_ATOMS-1:0][TAG_W-1:0]      atom_tag;
  } keys_t;

endpackage

// ----- rtl/rtsf_mix.sv -----
// splitmix64 finalizer, three register stages; each 64-bit multiply mod 2^64
// is split into three 32x32 partial products.
module rtsf_mix import rtsf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [HASH_W-1:0] x,
  output logic [HASH_W-1:0] y
);

  logic [HASH_W-1:0] a1;
  logic [HASH_W-1:0] s1_ll_r;
  logic [31:0]       s1_hl_r;
  logic [31:0]       s1_lh_r;

  logic [HASH_W-1:0] m1;
  logic [HASH_W-1:0] b2;
  logic [HASH_W-1:0] s2_ll_r;
  logic [31:0]       s2_hl_r;
  logic [31:0]       s2_lh_r;

  logic [HASH_W-1:0] m2;
  logic [HASH_W-1:0] y_r;

  assign a1 = x ^ (x >> SHIFT_A);
  assign m1 = s1_ll_r + {s1_hl_r + s1_lh_r, 32'd0};
  assign b2 = m1 ^ (m1 >> SHIFT_B);
  assign m2 = s2_ll_r + {s2_hl_r + s2_lh_r, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ll_r <= {32'd0, a1[31:0]} * {32'd0, MIX_C1[31:0]};
      s1_hl_r <= 32'(a1[63:32] * MIX_C1[31:0]);
      s1_lh_r <= 32'(a1[31:0] * MIX_C1[63:32]);
      s2_ll_r <= {32'd0, b2[31:0]} * {32'd0, MIX_C2[31:0]};
      s2_hl_r <= 32'(b2[63:32] * MIX_C2[31:0]);
      s2_lh_r <= 32'(b2[31:0] * MIX_C2[63:32]);
      y_r     <= m2 ^ (m2 >> SHIFT_C);
    end
  end

  assign y = y_r;

endmodule

// ----- rtl/rtsf_keys.sv -----
// Config registers and a small sequencer that derives seed_mix and the
// per-atom wanted tags through one shared finalizer after reset and after
// every write.
module rtsf_keys import rtsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [HASH_W-1:0] cfg_data,
  output logic              busy,
  output keys_t             keys
);

  localparam logic [3:0] SEQ_SEED     = 4'd1;
  localparam logic [3:0] SEQ_SEED_CAP = 4'd4;
  localparam logic [3:0] SEQ_ATOM0    = 4'd5;
  localparam logic [3:0] SEQ_TAG0     = 4'd8;
  localparam logic [3:0] SEQ_LAST     = 4'd11;

  logic [HASH_W-1:0]               hash_seed_r;
  mode_t                           expr_mode_r;
  logic [NUM_ATOMS*FLD_W-1:0]      atom_fields_r;
  logic [NUM_ATOMS-1:0][COL_W-1:0] atom_value_r;
  logic [HASH_W-1:0]               seed_mix_r;
  logic [NUM_ATOMS-1:0][TAG_W-1:0] atom_tag_r;
  logic [3:0]                      seq_r;
  logic [3:0]                      seq_nxt;

  logic [3:0]        feed_off;
  logic [3:0]        cap_off;
  logic [1:0]        feed_k;
  logic [1:0]        cap_k;
  logic [FLD_W-1:0]  feed_fld;
  logic [HASH_W-1:0] mix_x;
  logic [HASH_W-1:0] mix_y;

  assign feed_off = seq_r - SEQ_ATOM0;
  assign cap_off  = seq_r - SEQ_TAG0;
  assign feed_k   = feed_off[1:0];
  assign cap_k    = cap_off[1:0];
  assign feed_fld = atom_fields_r[feed_k*FLD_W +: FLD_W];

  always_comb begin
    if (seq_r == SEQ_SEED) begin
      mix_x = hash_seed_r;
    end else begin
      mix_x = {{(HASH_W-FLD_W-COL_W){1'b0}}, feed_fld, atom_value_r[feed_k]} ^ seed_mix_r;
    end
  end

  rtsf_mix u_mix (
    .clk (clk),
    .en  (1'b1),
    .x   (mix_x),
    .y   (mix_y)
  );

  always_comb begin
    if (cfg_valid) begin
      seq_nxt = SEQ_SEED;
    end else if (seq_r == SEQ_LAST) begin
      seq_nxt = 4'd0;
    end else if (seq_r != 4'd0) begin
      seq_nxt = seq_r + 4'd1;
    end else begin
      seq_nxt = seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r   <= '0;
      expr_mode_r   <= MODE_BOTH;
      atom_fields_r <= ATOM_FIELDS_RST;
      atom_value_r  <= '0;
      seq_r         <= SEQ_SEED;
    end else begin
      seq_r <= seq_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_HASH_SEED:   hash_seed_r     <= cfg_data;
          REG_EXPR_MODE:   expr_mode_r     <= mode_t'(cfg_data[1:0]);
          REG_ATOM_FIELDS: atom_fields_r   <= cfg_data[NUM_ATOMS*FLD_W-1:0];
          REG_ATOM_VALUE0: atom_value_r[0] <= cfg_data[COL_W-1:0];
          REG_ATOM_VALUE1: atom_value_r[1] <= cfg_data[COL_W-1:0];
          REG_ATOM_VALUE2: atom_value_r[2] <= cfg_data[COL_W-1:0];
          REG_ATOM_VALUE3: atom_value_r[3] <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_r == SEQ_SEED_CAP) begin
      seed_mix_r <= mix_y;
    end
    if (seq_r inside {[SEQ_TAG0:SEQ_LAST]}) begin
      atom_tag_r[cap_k] <= mix_y[TAG_W-1:0];
    end
  end

  assign busy             = (seq_r != 4'd0);
  assign keys.expr_mode   = expr_mode_r;
  assign keys.atom_fields = atom_fields_r;
  assign keys.atom_value  = atom_value_r;
  assign keys.seed_mix    = seed_mix_r;
  assign keys.atom_tag    = atom_tag_r;

endmodule

// ----- rtl/rtsf_merge.sv -----
// Packs lane tags into the row code and evaluates the predicate on tags and
// on the exact-value atom hits carried down the pipe.
module rtsf_merge import rtsf_pkg::*; (
  input  logic [NUM_COLS-1:0][TAG_W-1:0] tags,
  input  logic [NUM_ATOMS-1:0]           exact_hit,
  input  keys_t                          keys,
  output logic [8*TAG_W-1:0]             row_code,
  output logic                           candidate,
  output logic                           exact_match
);

  logic [NUM_ATOMS-1:0] tag_hit;
  logic [FLD_W-1:0]     fld;

  function automatic logic combine(mode_t mode, logic [NUM_ATOMS-1:0] a);
    logic r;
    case (mode)
      MODE_ONE:    r = a[0];
      MODE_BOTH:   r = a[0] & a[1];
      MODE_EITHER: r = (a[0] & a[1]) | a[2];
      MODE_CNF:    r = (a[0] | a[2]) & (a[1] | a[3]);
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    row_code = '0;
    for (int j = 0; j < NUM_COLS; j++) begin
      row_code[j*TAG_W +: TAG_W] = tags[j];
    end
  end

  always_comb begin
    tag_hit = '0;
    fld     = '0;
    for (int k = 0; k < NUM_ATOMS; k++) begin
      fld = keys.atom_fields[k*FLD_W +: FLD_W];
      if (int'(fld) < NUM_COLS) begin
        tag_hit[k] = (tags[fld] == keys.atom_tag[k]);
      end
    end
  end

  assign candidate   = combine(keys.expr_mode, tag_hit);
  assign exact_match = combine(keys.expr_mode, exact_hit);

endmodule

// ----- rtl/row_tag_signature_filter.sv -----
// Row tag signature filter.
// One row of eight 32-bit fields enters on the in_ stream per transfer; one
// result (row_code, candidate, exact_match) leaves on the out_ stream per row.
// Each field is hashed in its own lane; a merge stage packs the tags and
// evaluates the configured predicate on tags and on exact values.
// Throughput: one row per cycle while out_tready is high and the keys are idle.
// A row passes the input register, three finalizer stages in the lanes and
// the output register.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// After reset and after every config write, a shared finalizer recomputes the
// seed mix and the four wanted atom tags; in_tready stays low meanwhile.
// When out_tready is low with a result waiting, the whole pipe holds and
// in_tready drops in the same cycle; no row is lost or repeated.
// Reset (rst_n low, synchronous) clears the pipe and loads register defaults.
module row_tag_signature_filter import rtsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [NUM_COLS*COL_W-1:0] in_tdata,   // col0 .. col7, 32 bits each
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // row_code[31:0], candidate, exact_match, 6'b0
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [HASH_W-1:0]         cfg_data
);

  keys_t keys;
  logic  busy;
  logic  adv;

  logic [NUM_COLS-1:0][COL_W-1:0] vals_r;
  logic [NUM_ATOMS-1:0]           in_hit;
  logic [3:0]                     v_r;
  logic [3:0][NUM_ATOMS-1:0]      hit_r;

  logic [NUM_COLS-1:0][HASH_W-1:0] lane_y;
  logic [NUM_COLS-1:0][TAG_W-1:0]  tags;

  logic [8*TAG_W-1:0] row_code;
  logic               candidate;
  logic               exact_match;

  logic               out_valid_r;
  logic [8*TAG_W-1:0] out_code_r;
  logic               out_cand_r;
  logic               out_exact_r;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && !busy;

  rtsf_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .keys      (keys)
  );

  // exact-value atom hits are resolved at the input and carried along
  always_comb begin
    in_hit = '0;
    for (int k = 0; k < NUM_ATOMS; k++) begin
      if (int'(keys.atom_fields[k*FLD_W +: FLD_W]) < NUM_COLS) begin
        in_hit[k] = (in_tdata[keys.atom_fields[k*FLD_W +: FLD_W]*COL_W +: COL_W]
                     == keys.atom_value[k]);
      end
    end
  end

  genvar j;
  generate
    for (j = 0; j < NUM_COLS; j++) begin : g_lane
      rtsf_mix u_lane (
        .clk (clk),
        .en  (adv),
        .x   ({{(HASH_W-FLD_W-COL_W){1'b0}}, FLD_W'(j), vals_r[j]} ^ keys.seed_mix),
        .y   (lane_y[j])
      );
      assign tags[j] = lane_y[j][TAG_W-1:0];
    end
  endgenerate

  rtsf_merge u_merge (
    .tags        (tags),
    .exact_hit   (hit_r[3]),
    .keys        (keys),
    .row_code    (row_code),
    .candidate   (candidate),
    .exact_match (exact_match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[2:0], in_tvalid && in_tready};
      out_valid_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        vals_r[c] <= in_tdata[c*COL_W +: COL_W];
      end
      hit_r       <= {hit_r[2:0], in_hit};
      out_code_r  <= row_code;
      out_cand_r  <= candidate;
      out_exact_r <= exact_match;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_exact_r, out_cand_r, out_code_r};

endmodule

// ----- tb/sv/row_tag_signature_filter_tb.sv -----
`timescale 1ns / 1ps

module row_tag_signature_filter_tb;
  import rtsf_pkg::*;

  localparam logic [IDX_W-1:0] REG_PAST_END = 3'd7;  // no register here, write is dropped
  localparam int PIPE_SETTLE = 8;
  localparam int PHASES = 8;
  localparam int ROWS_PER_PHASE = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_ROW = 1000;

  typedef struct {
    logic [31:0] row_code;
    logic        candidate;
    logic        exact_match;
  } row_result_t;

  class row_scoreboard;
    logic [HASH_W-1:0]               seed;
    mode_t                           mode;
    logic [NUM_ATOMS*FLD_W-1:0]      atom_fields;
    logic [NUM_ATOMS-1:0][COL_W-1:0] atom_value;
    row_result_t                     expected_rows[$];
    int                              errors;

    function new();
      seed        = '0;
      mode        = MODE_BOTH;
      atom_fields = 12'd1672;
      atom_value  = '0;
      errors      = 0;
    endfunction

    function logic [63:0] mix64(logic [63:0] x);
      x = (x ^ (x >> SHIFT_A)) * MIX_C1;
      x = (x ^ (x >> SHIFT_B)) * MIX_C2;
      return x ^ (x >> SHIFT_C);
    endfunction

    function logic [3:0] lane_tag(logic [2:0] f, logic [31:0] v, logic [63:0] seed_mix);
      logic [63:0] h;
      h = mix64({29'd0, f, v} ^ seed_mix);
      return h[3:0];
    endfunction

    function logic holds(logic [3:0] a);
      case (mode)
        MODE_ONE:    return a[0];
        MODE_BOTH:   return a[0] & a[1];
        MODE_EITHER: return (a[0] & a[1]) | a[2];
        default:     return (a[0] | a[2]) & (a[1] | a[3]);
      endcase
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [HASH_W-1:0] data);
      case (idx)
        REG_HASH_SEED:   seed = data;
        REG_EXPR_MODE:   mode = mode_t'(data[1:0]);
        REG_ATOM_FIELDS: atom_fields = data[11:0];
        REG_ATOM_VALUE0: atom_value[0] = data[31:0];
        REG_ATOM_VALUE1: atom_value[1] = data[31:0];
        REG_ATOM_VALUE2: atom_value[2] = data[31:0];
        REG_ATOM_VALUE3: atom_value[3] = data[31:0];
        default: ;
      endcase
    endfunction

    function void note_row(logic [NUM_COLS*COL_W-1:0] row);
      logic [7:0][31:0] cols;
      logic [7:0][3:0]  tags;
      logic [63:0]      seed_mix;
      logic [3:0]       tag_hit;
      logic [3:0]       val_hit;
      logic [2:0]       f;
      row_result_t      r;
      cols     = row;
      seed_mix = mix64(seed);
      tags     = '0;
      for (int j = 0; j < 8; j++)
        if (j < NUM_COLS) tags[j] = lane_tag(3'(j), cols[j], seed_mix);
      for (int k = 0; k < NUM_ATOMS; k++) begin
        f = atom_fields[3*k +: 3];
        // atom on a lane past NUM_COLS never holds
        tag_hit[k] = (f < NUM_COLS) && (tags[f] == lane_tag(f, atom_value[k], seed_mix));
        val_hit[k] = (f < NUM_COLS) && (cols[f] == atom_value[k]);
      end
      r.row_code    = tags;
      r.candidate   = holds(tag_hit);
      r.exact_match = holds(val_hit);
      expected_rows = {expected_rows, r};
    endfunction

    function void check_result(logic [39:0] d);
      row_result_t e;
      if (expected_rows.size() == 0) begin
        if (errors < 10) $display("unexpected result transfer: data=%h", d);
        errors++;
        return;
      end
      e = expected_rows.pop_front();
      if (d[31:0] !== e.row_code || d[32] !== e.candidate || d[33] !== e.exact_match ||
          d[39:34] !== 6'd0) begin
        if (errors < 10)
          $display("mismatch: row_code exp %h got %h, candidate exp %b got %b,",
                   e.row_code, d[31:0], e.candidate, d[32],
                   " exact exp %b got %b, pad %b", e.exact_match, d[33], d[39:34]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [NUM_COLS*COL_W-1:0] in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [39:0]               out_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index;
  logic [HASH_W-1:0]         cfg_data;

  row_scoreboard sb;
  bit            calm;
  int            rows_in;

  row_tag_signature_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("row_tag_signature_filter_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        sb.note_row(in_tdata);
        rows_in++;
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // result side: random stalls, plus one long hold-off to back the pipe up
  initial begin : receiver
    int  hold_cnt;
    bit  held;
    hold_cnt   = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && rows_in >= HOLD_AT_ROW) begin
        held     = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_row(input logic [NUM_COLS*COL_W-1:0] row);
    while (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // junk above each register's width must be dropped
  task automatic configure(input logic [63:0] seed, input mode_t mode,
                           input logic [11:0] fields, input logic [3:0][31:0] vals);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_cfg(REG_HASH_SEED, seed);
    write_cfg(REG_EXPR_MODE, {junk[63:2], mode});
    write_cfg(REG_ATOM_FIELDS, {junk[63:12], fields});
    write_cfg(REG_ATOM_VALUE0, {junk[63:32], vals[0]});
    write_cfg(REG_ATOM_VALUE1, {junk[31:0], vals[1]});
    write_cfg(REG_ATOM_VALUE2, {~junk[63:32], vals[2]});
    write_cfg(REG_ATOM_VALUE3, {~junk[31:0], vals[3]});
    write_cfg(REG_PAST_END, junk);
    cfg_valid <= 1'b0;
  endtask

  // atoms in mask get their wanted value; others sometimes get a one-bit near miss
  function automatic logic [NUM_COLS*COL_W-1:0] make_row(input logic [3:0] mask);
    logic [7:0][31:0] cols;
    logic [2:0]       f;
    for (int j = 0; j < 8; j++) begin
      case ($urandom_range(9))
        0:       cols[j] = 32'd0;
        1:       cols[j] = 32'hffff_ffff;
        default: cols[j] = $urandom;
      endcase
    end
    for (int k = 0; k < NUM_ATOMS; k++) begin
      f = sb.atom_fields[3*k +: 3];
      if (mask[k]) cols[f] = sb.atom_value[k];
      else if ($urandom_range(2) == 0)
        cols[f] = sb.atom_value[k] ^ (32'd1 << $urandom_range(31));
    end
    return cols;
  endfunction

  initial begin
    logic [63:0]      seed;
    logic [11:0]      fields;
    logic [3:0][31:0] vals;
    logic [31:0]      shared;
    sb        = new();
    calm      = 1'b0;
    rows_in   = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: both atoms on fields 0 and 1, wanted value zero
    send_row('0);
    send_row('1);
    send_row(make_row(4'b0011));
    send_row({{(NUM_COLS*COL_W-64){1'b0}}, 32'd1, 32'd0});

    for (int m = 0; m < 4; m++) begin
      drain();
      vals = {$urandom, $urandom, $urandom, $urandom};
      configure({$urandom, $urandom}, mode_t'(m),
                (m == 0) ? 12'hfff : {3'd7, 3'd4, 3'd2, 3'd1}, vals);
      send_row(make_row(4'h0));
      send_row(make_row(4'hf));
      send_row(make_row(4'h3));
      send_row(make_row(4'h5));
      send_row(make_row(4'ha));
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      seed   = (p == 1) ? '1 : (p == 2) ? '0 : {$urandom, $urandom};
      fields = (p == 3) ? 12'hfff : (p == 6) ? 12'h000 : 12'($urandom_range(4095));
      shared = $urandom;
      case (p)
        4:       vals = '0;
        5:       vals = '1;
        7:       vals = {shared, shared, shared, shared};
        default: vals = {$urandom, $urandom, $urandom, $urandom};
      endcase
      configure(seed, mode_t'(p % 4), fields, vals);
      calm = (p == 2);
      for (int i = 0; i < ROWS_PER_PHASE; i++)
        send_row(make_row(($urandom_range(3) == 0) ? 4'hf : 4'($urandom_range(15))));
      calm = 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("row_tag_signature_filter_tb OK");
    end else begin
      $display("row_tag_signature_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
